// ===== hw/rtl/seio_pkg.sv =====
`default_nettype none
package seio_pkg;

  localparam int PROG_BITS = 16;
  localparam int ANG_W     = 15;
  localparam int DUR_W     = 16;
  localparam int ADV_W     = 8;
  localparam int PULSE_W   = 12;

  localparam int T_W    = PROG_BITS + 1;
  localparam int SPAN_W = ANG_W + 1;
  localparam int MUL_W  = (T_W + 1 > SPAN_W + 1) ? T_W + 1 : SPAN_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CNT_W  = $clog2(PROG_BITS + 1);

  localparam logic [T_W-1:0] T_ONE  = T_W'(1) << PROG_BITS;
  localparam logic [T_W-1:0] T_HALF = T_W'(1) << (PROG_BITS - 1);

  // floor(a/9) = floor((a + 9*1821) * ceil(2^19/9) / 2^19) - 1821
  localparam int             X_W        = ANG_W + 2;
  localparam logic [X_W-1:0] DIV9_OFS   = X_W'(16389);
  localparam logic [16:0]    DIV9_RECIP = 17'd58255;
  localparam int             DIV9_SHIFT = 19;
  localparam int             Q_W        = 13;
  localparam logic [Q_W:0]   PULSE_BIAS = (Q_W + 1)'(1821 - 1500);

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_START_ANGLE   = 2'd0;
  localparam logic [1:0] REG_END_ANGLE     = 2'd1;
  localparam logic [1:0] REG_MOVE_DURATION = 2'd2;

  localparam logic [ANG_W-1:0] START_RST = ANG_W'(0);
  localparam logic [ANG_W-1:0] END_RST   = ANG_W'(9000);
  localparam logic [DUR_W-1:0] DUR_RST   = DUR_W'(1000);

  typedef struct packed {
    logic signed [ANG_W-1:0] start_angle;
    logic signed [ANG_W-1:0] end_angle;
    logic [DUR_W-1:0]        move_duration;
  } seio_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_EASE,
    ST_SPAN,
    ST_ANG,
    ST_DIV9,
    ST_PULSE
  } seio_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/seio_if.sv =====
`default_nettype none
interface seio_in_if;
  logic                          valid;
  logic                          ready;
  logic                          restart;
  logic [seio_pkg::ADV_W-1:0]    advance_ms;
  modport source (output valid, output restart, output advance_ms, input ready);
  modport sink (input valid, input restart, input advance_ms, output ready);
endinterface

interface seio_out_if;
  logic                              valid;
  logic                              ready;
  logic [seio_pkg::PULSE_W-1:0]      pulse_us;
  logic signed [seio_pkg::ANG_W-1:0] angle_now;
  logic                              done_res;
  modport source (output valid, output pulse_us, output angle_now, output done_res,
                  input ready);
  modport sink (input valid, input pulse_us, input angle_now, input done_res,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/servo_ease_in_out_profile.sv =====
`default_nettype none
// One item at a time: a new item is accepted only when idle, after the previous
// result is in the output register, which may wait on out_if.ready. Work per item is
// the 16-step serial divider for progress plus the shared multiplier used three times.
// Reset (rst_n, synchronous, active low): elapsed time cleared, registers to defaults,
// sequencer idle, no result pending.
module servo_ease_in_out_profile (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  seio_in_if.sink                             in_if,
  seio_out_if.source                          out_if,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [seio_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [seio_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic      [seio_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                                cfg_pready
);
  import seio_pkg::*;

  seio_cfg_t cfg;

  seio_state_t state_r, state_nxt;

  logic [DUR_W-1:0]        elapsed_r, elapsed_nxt;
  logic [T_W-1:0]          sq_r, sq_nxt;
  logic                    lower_r, lower_nxt;
  logic [T_W-1:0]          e_r, e_nxt;
  logic signed [ANG_W-1:0] angle_r, angle_nxt;
  logic                    done_r, done_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [PULSE_W-1:0]      out_pulse_r, out_pulse_nxt;
  logic signed [ANG_W-1:0] out_angle_r, out_angle_nxt;
  logic                    out_done_r, out_done_nxt;

  logic                     accept;
  logic                     div_start;
  logic                     div_done;
  logic [T_W-1:0]           div_q;
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  logic [DUR_W:0]           sum;
  logic [DUR_W:0]           el_raw;
  logic [T_W-1:0]           t_c;
  logic [T_W-1:0]           sqr;
  logic [SPAN_W-1:0]        span;
  logic signed [PROD_W-1:0] shifted;
  logic [X_W-1:0]           x;
  logic [Q_W-1:0]           q9;
  logic [Q_W:0]             pulse_s;

  seio_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  seio_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed_nxt),
    .divisor  (cfg.move_duration),
    .done     (div_done),
    .quotient (div_q)
  );

  seio_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign in_if.ready      = state_r == ST_IDLE;
  assign accept           = in_if.valid && in_if.ready;
  assign div_start        = accept && cfg.move_duration != '0;
  assign out_if.valid     = out_valid_r;
  assign out_if.pulse_us  = out_pulse_r;
  assign out_if.angle_now = out_angle_r;
  assign out_if.done_res  = out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_r        <= sq_nxt;
    lower_r     <= lower_nxt;
    e_r         <= e_nxt;
    angle_r     <= angle_nxt;
    done_r      <= done_nxt;
    out_pulse_r <= out_pulse_nxt;
    out_angle_r <= out_angle_nxt;
    out_done_r  <= out_done_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    elapsed_nxt   = elapsed_r;
    sq_nxt        = sq_r;
    lower_nxt     = lower_r;
    e_nxt         = e_r;
    angle_nxt     = angle_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_pulse_nxt = out_pulse_r;
    out_angle_nxt = out_angle_r;
    out_done_nxt  = out_done_r;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    sum     = {1'b0, elapsed_r} + (DUR_W+1)'(in_if.advance_ms);
    el_raw  = in_if.restart ? '0 : sum;
    t_c     = (div_q > T_ONE) ? T_ONE : div_q;
    sqr     = mul_p[PROG_BITS-1 +: T_W];
    span    = {cfg.end_angle[ANG_W-1], cfg.end_angle}
            - {cfg.start_angle[ANG_W-1], cfg.start_angle};
    shifted = mul_p >>> PROG_BITS;
    x       = {{2{angle_r[ANG_W-1]}}, angle_r} + DIV9_OFS;
    q9      = mul_p[DIV9_SHIFT +: Q_W];
    pulse_s = {1'b0, q9} - PULSE_BIAS;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          elapsed_nxt = (el_raw > {1'b0, cfg.move_duration}) ? cfg.move_duration
                                                             : el_raw[DUR_W-1:0];
          done_nxt    = elapsed_nxt >= cfg.move_duration;
          if (cfg.move_duration == '0) begin
            angle_nxt = cfg.end_angle;
            state_nxt = ST_DIV9;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          lower_nxt = t_c < T_HALF;
          sq_nxt    = (t_c < T_HALF) ? t_c : T_ONE - t_c;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(sq_r);
        mul_b     = MUL_W'(sq_r);
        state_nxt = ST_EASE;
      end
      ST_EASE: begin
        e_nxt     = lower_r ? sqr : T_ONE - sqr;
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(signed'(span));
        mul_b     = MUL_W'(e_r);
        state_nxt = ST_ANG;
      end
      ST_ANG: begin
        angle_nxt = cfg.start_angle + shifted[ANG_W-1:0];
        state_nxt = ST_DIV9;
      end
      ST_DIV9: begin
        mul_en    = 1'b1;
        mul_a     = MUL_W'(x);
        mul_b     = MUL_W'(DIV9_RECIP);
        state_nxt = ST_PULSE;
      end
      ST_PULSE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_pulse_nxt = pulse_s[Q_W] ? '0 : pulse_s[PULSE_W-1:0];
          out_angle_nxt = angle_r;
          out_done_nxt  = done_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/seio_cfg.sv =====
`default_nettype none
module seio_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [seio_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [seio_pkg::CFG_DW-1:0]    pwdata,
  output logic      [seio_pkg::CFG_DW-1:0]    prdata,
  output logic                                pready,
  output seio_pkg::seio_cfg_t                 cfg
);
  import seio_pkg::*;

  seio_cfg_t  cfg_r;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_angle   <= START_RST;
      cfg_r.end_angle     <= END_RST;
      cfg_r.move_duration <= DUR_RST;
    end else if (wr) begin
      case (idx)
        REG_START_ANGLE:   cfg_r.start_angle   <= pwdata[ANG_W-1:0];
        REG_END_ANGLE:     cfg_r.end_angle     <= pwdata[ANG_W-1:0];
        REG_MOVE_DURATION: cfg_r.move_duration <= pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_ANGLE:   prdata = CFG_DW'(cfg_r.start_angle);
      REG_END_ANGLE:     prdata = CFG_DW'(cfg_r.end_angle);
      REG_MOVE_DURATION: prdata = CFG_DW'(cfg_r.move_duration);
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/seio_div.sv =====
`default_nettype none
module seio_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [seio_pkg::DUR_W-1:0]   dividend,
  input  wire logic [seio_pkg::DUR_W-1:0]   divisor,
  output logic                              done,
  output logic [seio_pkg::T_W-1:0]          quotient
);
  import seio_pkg::*;

  // restoring division of dividend * 2^PROG_BITS by divisor, dividend <= divisor
  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DUR_W-1:0] rem_r;
  logic [T_W-1:0]   q_r;

  logic             first;
  logic [DUR_W-1:0] rem_first;
  logic [DUR_W:0]   r2;
  logic             ge;
  logic [DUR_W:0]   r2_sub;

  always_comb begin
    first     = dividend >= divisor;
    rem_first = first ? dividend - divisor : dividend;
    r2        = {rem_r, 1'b0};
    ge        = r2 >= {1'b0, divisor};
    r2_sub    = r2 - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(PROG_BITS);
    end else if (busy_r && cnt_r != '0) begin
      cnt_r  <= cnt_r - CNT_W'(1);
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_first;
      q_r   <= {{(T_W-1){1'b0}}, first};
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= ge ? r2_sub[DUR_W-1:0] : r2[DUR_W-1:0];
      q_r   <= {q_r[T_W-2:0], ge};
    end
  end

  assign done     = busy_r && cnt_r == '0;
  assign quotient = q_r;

endmodule
`default_nettype wire

// ===== hw/rtl/seio_mul.sv =====
`default_nettype none
module seio_mul (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [seio_pkg::MUL_W-1:0]   a,
  input  wire logic signed [seio_pkg::MUL_W-1:0]   b,
  output logic signed [seio_pkg::PROD_W-1:0]       p
);
  import seio_pkg::*;

  logic signed [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ===== tb/servo_ease_in_out_profile_test.sv =====
`timescale 1ns / 1ps
module servo_ease_in_out_profile_test;
  import seio_pkg::*;

  localparam int         STALL_LIMIT = 5000;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         HOLD_CYCLES = 300;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [PULSE_W-1:0]      pulse_us;
    logic signed [ANG_W-1:0] angle_now;
    logic                    done_res;
  } servo_pos_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  seio_in_if  in_ch();
  seio_out_if out_ch();

  servo_ease_in_out_profile DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  int          start_cd;
  int          end_cd;
  int unsigned move_len_ms;
  int unsigned elapsed_ms;
  servo_pos_t  pending_positions[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          gaps_on;
  bit          stall_en;
  bit          hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic servo_pos_t next_position(input logic restart,
                                               input logic [ADV_W-1:0] adv);
    longint unsigned one_q, t, e, u;
    longint          span, ang;
    int              q, pulse;
    servo_pos_t      r;
    one_q = 64'd1 << PROG_BITS;
    if (restart) elapsed_ms = 0;
    else elapsed_ms = elapsed_ms + adv;
    if (elapsed_ms > move_len_ms) elapsed_ms = move_len_ms;
    if (move_len_ms == 0) begin
      ang = end_cd;
      r.done_res = 1'b1;
    end else begin
      t = (64'(elapsed_ms) << PROG_BITS) / 64'(move_len_ms);
      if (t > one_q) t = one_q;
      if (t < (one_q >> 1)) begin
        e = (t * t) >> (PROG_BITS - 1);
      end else begin
        u = one_q - t;
        e = one_q - ((u * u) >> (PROG_BITS - 1));
      end
      span = longint'(end_cd) - longint'(start_cd);
      ang = longint'(start_cd) + ((span * longint'(e)) >>> PROG_BITS);
      r.done_res = (elapsed_ms >= move_len_ms);
    end
    // floor division by 9
    q = (ang >= 0) ? int'(ang / 9) : -int'((-ang + 8) / 9);
    pulse = 1500 + q;
    if (pulse < 0) pulse = 0;
    if (pulse > 4095) pulse = 4095;
    r.pulse_us = pulse[PULSE_W-1:0];
    r.angle_now = ang[ANG_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    servo_pos_t got, want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.pulse_us, out_ch.angle_now, out_ch.done_res};
      if (pending_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: pulse=%0d angle=%0d done=%0b",
                   got.pulse_us, got.angle_now, got.done_res);
      end else begin
        want = pending_positions.pop_front();
        if (got.pulse_us !== want.pulse_us || got.angle_now !== want.angle_now ||
            got.done_res !== want.done_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pulse=%0d angle=%0d done=%0b, got pulse=%0d angle=%0d done=%0b",
                     want.pulse_us, want.angle_now, want.done_res,
                     got.pulse_us, got.angle_now, got.done_res);
        end
      end
    end
  end

  // result-side flow control
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_tick(input logic restart, input logic [ADV_W-1:0] adv);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.restart <= restart;
    in_ch.advance_ms <= adv;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_positions.push_back(next_position(restart, adv));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_positions.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_START_ANGLE:   start_cd = $signed(value[ANG_W-1:0]);
      REG_END_ANGLE:     end_cd = $signed(value[ANG_W-1:0]);
      REG_MOVE_DURATION: move_len_ms = value[DUR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_move(input int from_cd, input int to_cd, input int dur);
    wait_idle();
    write_reg(REG_START_ANGLE, from_cd);
    write_reg(REG_END_ANGLE, to_cd);
    write_reg(REG_MOVE_DURATION, dur);
  endtask

  task automatic test_default_move();
    send_tick(1'b1, 8'd255);
    send_tick(1'b0, 8'd0);
    send_tick(1'b0, 8'd255);
    send_tick(1'b0, 8'd255);
    send_tick(1'b0, 8'd255);
    send_tick(1'b0, 8'd200);
    send_tick(1'b0, 8'd1);
  endtask

  task automatic test_zero_duration();
    set_move(-9000, 9000, 0);
    send_tick(1'b1, 8'd0);
    send_tick(1'b0, 8'd255);
    send_tick(1'b0, 8'd0);
  endtask

  task automatic test_extreme_angles();
    // pulse saturates at zero at the far negative end
    set_move(-16384, 16383, 512);
    send_tick(1'b1, 8'd0);
    send_tick(1'b0, 8'd255);
    send_tick(1'b0, 8'd255);
    send_tick(1'b0, 8'd2);
    set_move(16383, -16384, 65535);
    send_tick(1'b1, 8'd17);
    send_tick(1'b0, 8'd255);
    send_tick(1'b0, 8'd128);
  endtask

  task automatic test_duration_cut();
    set_move(-9000, 9000, 1000);
    send_tick(1'b1, 8'd0);
    send_tick(1'b0, 8'd255);
    send_tick(1'b0, 8'd255);
    send_tick(1'b0, 8'd255);
    wait_idle();
    write_reg(REG_MOVE_DURATION, 300);
    send_tick(1'b0, 8'd0);
    send_tick(1'b0, 8'd17);
  endtask

  task automatic test_unused_register();
    wait_idle();
    write_reg(REG_UNUSED, 12345);
    send_tick(1'b0, 8'd1);
  endtask

  task automatic test_random_moves(input int phases, input int ticks);
    int from_cd, to_cd, dur, lim;
    for (int p = 0; p < phases; p++) begin
      if ($urandom_range(0, 5) == 0) begin
        from_cd = int'($urandom_range(0, 32767)) - 16384;
        to_cd = int'($urandom_range(0, 32767)) - 16384;
      end else begin
        from_cd = int'($urandom_range(0, 18000)) - 9000;
        to_cd = int'($urandom_range(0, 18000)) - 9000;
      end
      case ($urandom_range(0, 9))
        0:       dur = 0;
        1:       dur = 65535;
        2:       dur = $urandom_range(1, 8);
        default: dur = $urandom_range(9, 3000);
      endcase
      set_move(from_cd, to_cd, dur);
      lim = dur / 12 + 1;
      if (lim > 255) lim = 255;
      send_tick(1'b1, 8'($urandom));
      for (int i = 0; i < ticks; i++) begin
        if ($urandom_range(0, 15) == 0)
          send_tick(1'b1, 8'($urandom));
        else if ($urandom_range(0, 5) == 0)
          send_tick(1'b0, 8'($urandom_range(0, 255)));
        else
          send_tick(1'b0, 8'($urandom_range(0, lim)));
      end
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    stall_en = 1'b0;
    gaps_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_tick(1'b0, 8'($urandom_range(0, 120)));
    wait_idle();
    stall_en = 1'b1;
    gaps_on = 1'b1;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    in_ch.advance_ms = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    start_cd = 0;
    end_cd = 9000;
    move_len_ms = 1000;
    elapsed_ms = 0;
    gaps_on = 1'b1;
    stall_en = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_move();
    test_zero_duration();
    test_extreme_angles();
    test_duration_cut();
    test_unused_register();
    test_random_moves(10, 30);
    test_backpressure();
    gaps_on = 1'b0;
    stall_en = 1'b0;
    test_random_moves(2, 30);
    wait_idle();

    if (mismatches == 0 && pending_positions.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/seio_pkg.sv
hw/rtl/seio_if.sv
hw/rtl/seio_cfg.sv
hw/rtl/seio_div.sv
hw/rtl/seio_mul.sv
hw/rtl/servo_ease_in_out_profile.sv
tb/servo_ease_in_out_profile_test.sv
